// ----- rtl/wav_header_parser_unit_macros.svh -----
// Assertion macros for the WAV header parser unit.
// Used by the top level only; clock and reset are the top level port names.
`ifndef WAV_HEADER_PARSER_UNIT_MACROS_SVH
`define WAV_HEADER_PARSER_UNIT_MACROS_SVH

// same-cycle implication
`define WHP_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// delayed implication of the consequence from the antecedent
`define WHP_ASSERT_AFTER2(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> ##2 (cons)) \
      else $error(msg);

`endif

// ----- rtl/wavhp_pkg.sv -----
// Shared types and constants for the WAV header parser unit.
// No dependencies; used by every module of the block.
package wavhp_pkg;

   localparam logic [1:0] CMD_BYTE    = 2'd0;
   localparam logic [1:0] CMD_END     = 2'd1;
   localparam logic [1:0] CMD_RESTART = 2'd2;
   localparam logic [1:0] CMD_IGNORE  = 2'd3;

   localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
   localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
   localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
   localparam logic [31:0] TAG_DATA = 32'h6174_6164;

   localparam logic [31:0] FMT_MIN_LEN  = 32'd16;
   localparam logic [31:0] FMT_EXT_LEN  = 32'd18;
   localparam logic [15:0] FLOAT_BITS   = 16'd32;
   localparam logic [15:0] FORMAT_PCM   = 16'd1;
   localparam logic [15:0] FORMAT_FLOAT = 16'd3;

   typedef enum logic [1:0] {
      KIND_BYTE,
      KIND_END,
      KIND_RESTART
   } item_kind_type;

   typedef struct packed {
      item_kind_type kind;
      logic [7:0]    data;
   } queue_entry_type;

   typedef enum logic [3:0] {
      ST_OK          = 4'd0,
      ST_NOT_RIFF    = 4'd1,
      ST_NOT_WAVE    = 4'd2,
      ST_FMT_SHORT   = 4'd3,
      ST_BAD_TAG     = 4'd4,
      ST_NO_CHANNELS = 4'd5,
      ST_NO_RATE     = 4'd6,
      ST_BYTE_RATE   = 4'd7,
      ST_ALIGN       = 4'd8,
      ST_FLOAT_BITS  = 4'd9,
      ST_EXT_SIZE    = 4'd10,
      ST_TRUNCATED   = 4'd11
   } status_type;

   typedef enum logic [3:0] {
      PH_RIFF,
      PH_RSIZE,
      PH_WAVE,
      PH_CID,
      PH_CLEN,
      PH_SKIP,
      PH_TAG,
      PH_CHAN,
      PH_RATE,
      PH_BRATE,
      PH_ALIGN,
      PH_BITS,
      PH_EXT,
      PH_DONE,
      PH_CHECK
   } phase_type;

   typedef struct packed {
      logic        start;
      logic        is_float;
      logic [15:0] channels;
      logic [31:0] rate;
      logic [15:0] bits;
      logic [31:0] byte_rate;
      logic [15:0] align;
   } fmt_req_type;

   typedef struct packed {
      logic       done;
      status_type status;
   } fmt_rsp_type;

endpackage

// ----- rtl/wavhp_front.sv -----
// Front end: classifies incoming beats and holds them in a short queue.
// Depends on wavhp_pkg.
module wavhp_front #(
   parameter int DEPTH = 2
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [1:0]                 req_command,
   input  logic [7:0]                 req_data_byte,
   output logic                       q_valid,
   output wavhp_pkg::queue_entry_type q_head,
   input  logic                       q_pop
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   wavhp_pkg::queue_entry_type entry_ff [DEPTH];
   wavhp_pkg::queue_entry_type entry_in;
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push;
   logic             pop;

   always_comb begin
      entry_in.data = req_data_byte;
      unique case (req_command)
         wavhp_pkg::CMD_BYTE:    entry_in.kind = wavhp_pkg::KIND_BYTE;
         wavhp_pkg::CMD_END:     entry_in.kind = wavhp_pkg::KIND_END;
         wavhp_pkg::CMD_RESTART: entry_in.kind = wavhp_pkg::KIND_RESTART;
         default:                entry_in.kind = wavhp_pkg::KIND_BYTE;
      endcase
   end

   assign req_ready = (count_ff != CNT_W'(DEPTH));
   assign push      = req_valid && req_ready && (req_command != wavhp_pkg::CMD_IGNORE);
   assign q_valid   = (count_ff != '0);
   assign q_head    = entry_ff[rd_ptr_ff];
   assign pop       = q_pop && q_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= entry_in;
      end
   end

endmodule

// ----- rtl/wavhp_fmt_check.sv -----
// Two-stage multiply check of byte rate and block align, and of float sample bits, for a fmt chunk.
// Depends on wavhp_pkg.
module wavhp_fmt_check (
   input  logic                   clock,
   input  logic                   reset,
   input  wavhp_pkg::fmt_req_type fmt_req,
   output wavhp_pkg::fmt_rsp_type fmt_rsp
);

   logic        s1_ff, s1_in;
   logic        s2_ff, s2_in;
   logic [28:0] frame_ff, frame_in;
   logic [60:0] prod_ff, prod_in;
   logic        align_ok_ff, align_ok_in;
   logic        rate_ok;

   assign s1_in       = fmt_req.start;
   assign s2_in       = s1_ff;
   assign frame_in    = 29'(fmt_req.channels * fmt_req.bits[15:3]);
   assign prod_in     = 61'(fmt_req.rate * frame_ff);
   assign align_ok_in = (frame_ff == {13'b0, fmt_req.align});
   assign rate_ok     = (prod_ff[60:32] == '0) && (prod_ff[31:0] == fmt_req.byte_rate);

   always_comb begin
      fmt_rsp.done = s2_ff;
      if (!rate_ok) begin
         fmt_rsp.status = wavhp_pkg::ST_BYTE_RATE;
      end else if (!align_ok_ff) begin
         fmt_rsp.status = wavhp_pkg::ST_ALIGN;
      end else if (fmt_req.is_float && (fmt_req.bits != wavhp_pkg::FLOAT_BITS)) begin
         fmt_rsp.status = wavhp_pkg::ST_FLOAT_BITS;
      end else begin
         fmt_rsp.status = wavhp_pkg::ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff <= 1'b0;
         s2_ff <= 1'b0;
      end else begin
         s1_ff <= s1_in;
         s2_ff <= s2_in;
      end
   end

   always_ff @(posedge clock) begin
      frame_ff    <= frame_in;
      prod_ff     <= prod_in;
      align_ok_ff <= align_ok_in;
   end

endmodule

// ----- rtl/wavhp_back.sv -----
// Back end: chunk walker state machine, fmt field capture and result register.
// Depends on wavhp_pkg; drives wavhp_fmt_check through fmt_req.
module wavhp_back (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       q_valid,
   input  wavhp_pkg::queue_entry_type q_head,
   output logic                       q_pop,
   output wavhp_pkg::fmt_req_type     fmt_req,
   input  wavhp_pkg::fmt_rsp_type     fmt_rsp,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [3:0]                 rsp_status,
   output logic                       rsp_is_float,
   output logic [15:0]                rsp_channels,
   output logic [31:0]                rsp_sample_rate,
   output logic [5:0]                 rsp_sample_bits
);

   wavhp_pkg::phase_type phase_ff, phase_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic [23:0] shift_ff, shift_in;
   logic [31:0] chunk_ff, chunk_in;
   logic [15:0] tag_ff, tag_in;
   logic [15:0] chan_ff, chan_in;
   logic [31:0] rate_ff, rate_in;
   logic [31:0] brate_ff, brate_in;
   logic [15:0] align_ff, align_in;
   logic [15:0] bits_ff, bits_in;
   logic        finished_ff, finished_in;
   logic        start_ff, start_in;
   logic        out_valid_ff, out_valid_in;
   wavhp_pkg::status_type out_status_ff, out_status_in;
   logic        out_float_ff, out_float_in;
   logic [15:0] out_chan_ff, out_chan_in;
   logic [31:0] out_rate_ff, out_rate_in;
   logic [5:0]  out_bits_ff, out_bits_in;

   logic        out_free;
   logic [31:0] value;
   logic        emit;
   wavhp_pkg::status_type emit_status;
   logic [5:0]  report_bits;

   function automatic logic [1:0] last_index(input wavhp_pkg::phase_type ph);
      logic [1:0] idx;
      unique case (ph)
         wavhp_pkg::PH_RIFF, wavhp_pkg::PH_RSIZE, wavhp_pkg::PH_WAVE,
         wavhp_pkg::PH_CID, wavhp_pkg::PH_CLEN, wavhp_pkg::PH_RATE,
         wavhp_pkg::PH_BRATE:                                      idx = 2'd3;
         wavhp_pkg::PH_TAG, wavhp_pkg::PH_CHAN, wavhp_pkg::PH_ALIGN,
         wavhp_pkg::PH_BITS, wavhp_pkg::PH_EXT:                    idx = 2'd1;
         default:                                                  idx = 2'd0;
      endcase
      return idx;
   endfunction

   assign out_free = !out_valid_ff || rsp_ready;
   assign q_pop    = q_valid && out_free && (phase_ff != wavhp_pkg::PH_CHECK);
   assign value    = {8'b0, shift_ff} | ({24'b0, q_head.data} << {cnt_ff, 3'b000});

   always_comb begin
      if (tag_ff == wavhp_pkg::FORMAT_FLOAT) begin
         report_bits = 6'(wavhp_pkg::FLOAT_BITS);
      end else if ((tag_ff == wavhp_pkg::FORMAT_PCM) &&
                   ((bits_ff == 16'd8) || (bits_ff == 16'd16) ||
                    (bits_ff == 16'd24) || (bits_ff == 16'd32))) begin
         report_bits = bits_ff[5:0];
      end else begin
         report_bits = 6'd0;
      end
   end

   assign fmt_req.start     = start_ff;
   assign fmt_req.is_float  = (tag_ff == wavhp_pkg::FORMAT_FLOAT);
   assign fmt_req.channels  = chan_ff;
   assign fmt_req.rate      = rate_ff;
   assign fmt_req.bits      = bits_ff;
   assign fmt_req.byte_rate = brate_ff;
   assign fmt_req.align     = align_ff;

   always_comb begin
      phase_in     = phase_ff;
      cnt_in       = cnt_ff;
      shift_in     = shift_ff;
      chunk_in     = chunk_ff;
      tag_in       = tag_ff;
      chan_in      = chan_ff;
      rate_in      = rate_ff;
      brate_in     = brate_ff;
      align_in     = align_ff;
      bits_in      = bits_ff;
      finished_in  = finished_ff;
      start_in     = 1'b0;
      emit         = 1'b0;
      emit_status  = wavhp_pkg::ST_OK;
      out_valid_in = out_valid_ff && !rsp_ready;

      if (phase_ff == wavhp_pkg::PH_CHECK) begin
         if (fmt_rsp.done) begin
            if (fmt_rsp.status != wavhp_pkg::ST_OK) begin
               emit        = 1'b1;
               emit_status = fmt_rsp.status;
            end else begin
               phase_in = (chunk_ff > wavhp_pkg::FMT_MIN_LEN) ? wavhp_pkg::PH_EXT :
                                                              wavhp_pkg::PH_CID;
            end
         end
      end else if (q_pop) begin
         unique case (q_head.kind)
            wavhp_pkg::KIND_RESTART: begin
               phase_in    = wavhp_pkg::PH_RIFF;
               cnt_in      = '0;
               shift_in    = '0;
               chunk_in    = '0;
               tag_in      = '0;
               chan_in     = '0;
               rate_in     = '0;
               brate_in    = '0;
               align_in    = '0;
               bits_in     = '0;
               finished_in = 1'b0;
            end
            wavhp_pkg::KIND_END: begin
               if (!finished_ff) begin
                  emit        = 1'b1;
                  emit_status = wavhp_pkg::ST_TRUNCATED;
               end
            end
            default: begin
               if (!finished_ff) begin
                  if (phase_ff == wavhp_pkg::PH_SKIP) begin
                     chunk_in = chunk_ff - 32'd1;
                     if (chunk_ff == 32'd1) begin
                        phase_in = wavhp_pkg::PH_CID;
                     end
                  end else if (cnt_ff != last_index(phase_ff)) begin
                     cnt_in   = cnt_ff + 2'd1;
                     shift_in = value[23:0];
                  end else begin
                     cnt_in   = '0;
                     shift_in = '0;
                     unique case (phase_ff)
                        wavhp_pkg::PH_RIFF: begin
                           if (value != wavhp_pkg::TAG_RIFF) begin
                              emit        = 1'b1;
                              emit_status = wavhp_pkg::ST_NOT_RIFF;
                           end else begin
                              phase_in = wavhp_pkg::PH_RSIZE;
                           end
                        end
                        wavhp_pkg::PH_RSIZE: phase_in = wavhp_pkg::PH_WAVE;
                        wavhp_pkg::PH_WAVE: begin
                           if (value != wavhp_pkg::TAG_WAVE) begin
                              emit        = 1'b1;
                              emit_status = wavhp_pkg::ST_NOT_WAVE;
                           end else begin
                              phase_in = wavhp_pkg::PH_CID;
                           end
                        end
                        wavhp_pkg::PH_CID: begin
                           chunk_in = value;
                           phase_in = wavhp_pkg::PH_CLEN;
                        end
                        wavhp_pkg::PH_CLEN: begin
                           chunk_in = value;
                           if (chunk_ff == wavhp_pkg::TAG_DATA) begin
                              emit        = 1'b1;
                              emit_status = wavhp_pkg::ST_OK;
                           end else if (chunk_ff == wavhp_pkg::TAG_FMT) begin
                              if (value < wavhp_pkg::FMT_MIN_LEN) begin
                                 emit        = 1'b1;
                                 emit_status = wavhp_pkg::ST_FMT_SHORT;
                              end else begin
                                 phase_in = wavhp_pkg::PH_TAG;
                              end
                           end else begin
                              phase_in = (value == '0) ? wavhp_pkg::PH_CID :
                                                         wavhp_pkg::PH_SKIP;
                           end
                        end
                        wavhp_pkg::PH_TAG: begin
                           if ((value[15:0] != wavhp_pkg::FORMAT_PCM) &&
                               (value[15:0] != wavhp_pkg::FORMAT_FLOAT)) begin
                              emit        = 1'b1;
                              emit_status = wavhp_pkg::ST_BAD_TAG;
                           end else begin
                              tag_in   = value[15:0];
                              phase_in = wavhp_pkg::PH_CHAN;
                           end
                        end
                        wavhp_pkg::PH_CHAN: begin
                           if (value[15:0] == '0) begin
                              emit        = 1'b1;
                              emit_status = wavhp_pkg::ST_NO_CHANNELS;
                           end else begin
                              chan_in  = value[15:0];
                              phase_in = wavhp_pkg::PH_RATE;
                           end
                        end
                        wavhp_pkg::PH_RATE: begin
                           if (value == '0) begin
                              emit        = 1'b1;
                              emit_status = wavhp_pkg::ST_NO_RATE;
                           end else begin
                              rate_in  = value;
                              phase_in = wavhp_pkg::PH_BRATE;
                           end
                        end
                        wavhp_pkg::PH_BRATE: begin
                           brate_in = value;
                           phase_in = wavhp_pkg::PH_ALIGN;
                        end
                        wavhp_pkg::PH_ALIGN: begin
                           align_in = value[15:0];
                           phase_in = wavhp_pkg::PH_BITS;
                        end
                        wavhp_pkg::PH_BITS: begin
                           bits_in  = value[15:0];
                           start_in = 1'b1;
                           phase_in = wavhp_pkg::PH_CHECK;
                        end
                        wavhp_pkg::PH_EXT: begin
                           if (chunk_ff != wavhp_pkg::FMT_EXT_LEN + {16'b0, value[15:0]})
                           begin
                              emit        = 1'b1;
                              emit_status = wavhp_pkg::ST_EXT_SIZE;
                           end else begin
                              chunk_in = {16'b0, value[15:0]};
                              phase_in = (value[15:0] == '0) ? wavhp_pkg::PH_CID :
                                                               wavhp_pkg::PH_SKIP;
                           end
                        end
                        default: begin
                           finished_in = 1'b1;
                           phase_in    = wavhp_pkg::PH_DONE;
                        end
                     endcase
                  end
               end
            end
         endcase
      end

      out_status_in = out_status_ff;
      out_float_in  = out_float_ff;
      out_chan_in   = out_chan_ff;
      out_rate_in   = out_rate_ff;
      out_bits_in   = out_bits_ff;
      if (emit) begin
         out_valid_in  = 1'b1;
         out_status_in = emit_status;
         finished_in   = 1'b1;
         phase_in      = wavhp_pkg::PH_DONE;
         if (emit_status == wavhp_pkg::ST_OK) begin
            out_float_in = (tag_ff == wavhp_pkg::FORMAT_FLOAT);
            out_chan_in  = chan_ff;
            out_rate_in  = rate_ff;
            out_bits_in  = report_bits;
         end else begin
            out_float_in = 1'b0;
            out_chan_in  = '0;
            out_rate_in  = '0;
            out_bits_in  = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= wavhp_pkg::PH_RIFF;
         cnt_ff       <= '0;
         shift_ff     <= '0;
         chunk_ff     <= '0;
         tag_ff       <= '0;
         chan_ff      <= '0;
         rate_ff      <= '0;
         brate_ff     <= '0;
         align_ff     <= '0;
         bits_ff      <= '0;
         finished_ff  <= 1'b0;
         start_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         cnt_ff       <= cnt_in;
         shift_ff     <= shift_in;
         chunk_ff     <= chunk_in;
         tag_ff       <= tag_in;
         chan_ff      <= chan_in;
         rate_ff      <= rate_in;
         brate_ff     <= brate_in;
         align_ff     <= align_in;
         bits_ff      <= bits_in;
         finished_ff  <= finished_in;
         start_ff     <= start_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_status_ff <= out_status_in;
      out_float_ff  <= out_float_in;
      out_chan_ff   <= out_chan_in;
      out_rate_ff   <= out_rate_in;
      out_bits_ff   <= out_bits_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_status      = out_status_ff;
   assign rsp_is_float    = out_float_ff;
   assign rsp_channels    = out_chan_ff;
   assign rsp_sample_rate = out_rate_ff;
   assign rsp_sample_bits = out_bits_ff;

endmodule

// ----- rtl/wav_header_parser_unit.sv -----
// Accepted beats wait in the queue registers; a result is registered onto rsp in the cycle after the
// parser decides it. The beat closing the fmt bits field first passes start_ff and the two-stage multiply.
// Throughput: one beat per cycle, limited by the parser taking one queued beat per cycle
// and holding while the fmt multiply runs or a result waits on rsp_ready.
// Reset (synchronous): parser back to the RIFF tag, queue empty, no result pending.
`include "wav_header_parser_unit_macros.svh"
module wav_header_parser_unit #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_command,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [3:0]  rsp_status,
   output logic        rsp_is_float,
   output logic [15:0] rsp_channels,
   output logic [31:0] rsp_sample_rate,
   output logic [5:0]  rsp_sample_bits
);

   logic                       q_valid;
   logic                       q_pop;
   wavhp_pkg::queue_entry_type q_head;
   wavhp_pkg::fmt_req_type     fmt_req;
   wavhp_pkg::fmt_rsp_type     fmt_rsp;

   wavhp_front #(
      .DEPTH(QUEUE_DEPTH)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_command  (req_command),
      .req_data_byte(req_data_byte),
      .q_valid      (q_valid),
      .q_head       (q_head),
      .q_pop        (q_pop)
   );

   wavhp_fmt_check u_fmt_check (
      .clock  (clock),
      .reset  (reset),
      .fmt_req(fmt_req),
      .fmt_rsp(fmt_rsp)
   );

   wavhp_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_valid),
      .q_head         (q_head),
      .q_pop          (q_pop),
      .fmt_req        (fmt_req),
      .fmt_rsp        (fmt_rsp),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_is_float   (rsp_is_float),
      .rsp_channels   (rsp_channels),
      .rsp_sample_rate(rsp_sample_rate),
      .rsp_sample_bits(rsp_sample_bits)
   );

   `WHP_ASSERT_AFTER2(a_check_timing, fmt_req.start, fmt_rsp.done, "fmt check not done in time")
   `WHP_ASSERT_IMPLY(a_check_out_free, fmt_rsp.done, !rsp_valid, "fmt check ends with rsp busy")
   `WHP_ASSERT_IMPLY(a_full_has_head, !req_ready, q_valid, "queue full but parser sees no beat")
   `WHP_ASSERT_IMPLY(a_no_pop_in_check, fmt_req.start || fmt_rsp.done, !q_pop, "pop during check")

endmodule
